/* src/dhd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhd_pkg
// shared types, constants and the bit-field decode helper of the dictionary
// halfword decompressor
// ----------------------------------------------------------------------------
package dhd_pkg;

  localparam int IDX_BITS   = 6;
  localparam int DICT_DEPTH = 64;
  localparam int DICT_AW    = $clog2(DICT_DEPTH);
  localparam int LIT_BITS   = 16;
  localparam int BUF_BITS   = 24;
  localparam int CNT_W      = 5;
  localparam int LC_W       = 8;
  localparam int HDR_BYTES  = 4;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [BUF_BITS-1:0] IDX_MASK = BUF_BITS'((1 << IDX_BITS) - 1);

  typedef enum logic [1:0] {
    PH_SIZE   = 2'd0,
    PH_DICT   = 2'd1,
    PH_STREAM = 2'd2
  } phase_t;

  // one decoded symbol waiting for its dictionary read
  typedef struct packed {
    logic        valid;
    logic        lit;
    logic [15:0] value;
    logic        last;
  } sym_t;

  typedef struct packed {
    logic               en;
    logic [DICT_AW-1:0] addr;
    logic [15:0]        data;
  } dict_wr_t;

  typedef struct packed {
    logic [DICT_AW-1:0] addr0;
    logic [DICT_AW-1:0] addr1;
  } dict_rd_t;

  typedef struct packed {
    logic [15:0] halfword;
    logic        last;
  } out_t;

  typedef struct packed {
    logic                ok;
    logic                lit;
    logic [15:0]         value;
    logic [BUF_BITS-1:0] bits;
    logic [CNT_W-1:0]    cnt;
  } dec_t;

  // pull one flag+payload symbol off the top of the bit buffer
  function automatic dec_t decode_one(input logic [BUF_BITS-1:0] bits,
                                      input logic [CNT_W-1:0] cnt);
    dec_t                d;
    logic [CNT_W-1:0]    need;
    logic [CNT_W-1:0]    sh;
    logic [BUF_BITS-1:0] shifted;
    logic [BUF_BITS-1:0] keep;
    d       = '0;
    d.bits  = bits;
    d.cnt   = cnt;
    need    = '0;
    sh      = '0;
    shifted = '0;
    keep    = '0;
    if (cnt != '0) begin
      d.lit = bits[cnt - CNT_W'(1)];
      need  = d.lit ? CNT_W'(1 + LIT_BITS) : CNT_W'(1 + IDX_BITS);
      if (cnt >= need) begin
        sh      = cnt - need;
        shifted = bits >> sh;
        d.value = d.lit ? shifted[15:0] : 16'(shifted & IDX_MASK);
        keep    = (BUF_BITS'(1) << sh) - BUF_BITS'(1);
        d.bits  = bits & keep;
        d.cnt   = sh;
        d.ok    = 1'b1;
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

/* src/dhd_dict_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhd_dict_ram
// 64 x 16 dictionary, one write port and two registered read ports
// ----------------------------------------------------------------------------
module dhd_dict_ram
  import dhd_pkg::*;
(
  input  wire logic     clk,
  input  wire dict_wr_t wr,
  input  wire dict_rd_t rd,
  output logic [15:0]   rdata0,
  output logic [15:0]   rdata1
);

  logic [15:0] mem [DICT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata0 <= mem[rd.addr0];
    rdata1 <= mem[rd.addr1];
  end

endmodule
`default_nettype wire

/* src/dhd_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhd_parser
// header and dictionary loading, bit buffer, up to two symbols per byte
// ----------------------------------------------------------------------------
module dhd_parser
  import dhd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] byte_in,
  output dict_wr_t        dict_wr,
  output dict_rd_t        dict_rd,
  output sym_t            sym0_r,
  output sym_t            sym1_r
);

  phase_t              phase_r, phase_nxt;
  logic [LC_W-1:0]     lc_r, lc_nxt;
  logic [31:0]         asm_r, asm_nxt;
  logic [31:0]         rem_r, rem_nxt;
  logic [BUF_BITS-1:0] bits_r, bits_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  sym_t                sym0_nxt, sym1_nxt;

  logic [BUF_BITS-1:0] app_bits;
  logic [CNT_W-1:0]    app_cnt;
  dec_t                d0, d1;
  logic [31:0]         rem1, rem2;

  // new byte joins the buffer only if it fits
  always_comb begin
    app_bits = bits_r;
    app_cnt  = cnt_r;
    if (cnt_r <= CNT_W'(BUF_BITS - 8)) begin
      app_bits = {bits_r[BUF_BITS-9:0], byte_in};
      app_cnt  = cnt_r + CNT_W'(8);
    end
  end

  assign d0   = decode_one(app_bits, app_cnt);
  assign d1   = decode_one(d0.bits, d0.cnt);
  assign rem1 = rem_r - 32'd1;
  assign rem2 = rem_r - 32'd2;

  assign dict_rd.addr0 = d0.value[DICT_AW-1:0];
  assign dict_rd.addr1 = d1.value[DICT_AW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    lc_nxt    = lc_r;
    asm_nxt   = asm_r;
    rem_nxt   = rem_r;
    bits_nxt  = bits_r;
    cnt_nxt   = cnt_r;
    sym0_nxt  = '0;
    sym1_nxt  = '0;
    dict_wr   = '0;
    if (take) begin
      case (phase_r)
        PH_DICT: begin
          if (!lc_r[0]) begin
            asm_nxt = {24'd0, byte_in};
          end else begin
            dict_wr.en   = 1'b1;
            dict_wr.addr = lc_r[DICT_AW:1];
            dict_wr.data = {asm_r[7:0], byte_in};
          end
          lc_nxt = lc_r + LC_W'(1);
          if (lc_nxt >= LC_W'(2 * DICT_DEPTH)) begin
            lc_nxt    = '0;
            bits_nxt  = '0;
            cnt_nxt   = '0;
            phase_nxt = (rem_r != 32'd0) ? PH_STREAM : PH_SIZE;
          end
        end
        PH_STREAM: begin
          bits_nxt = app_bits;
          cnt_nxt  = app_cnt;
          if (d0.ok) begin
            sym0_nxt = '{valid: 1'b1, lit: d0.lit, value: d0.value,
                         last: (rem1 == 32'd0)};
            rem_nxt  = rem1;
            bits_nxt = d0.bits;
            cnt_nxt  = d0.cnt;
            if (rem1 == 32'd0) begin
              bits_nxt  = '0;
              cnt_nxt   = '0;
              phase_nxt = PH_SIZE;
              lc_nxt    = '0;
              asm_nxt   = '0;
            end else if (d1.ok) begin
              sym1_nxt = '{valid: 1'b1, lit: d1.lit, value: d1.value,
                           last: (rem2 == 32'd0)};
              rem_nxt  = rem2;
              bits_nxt = d1.bits;
              cnt_nxt  = d1.cnt;
              if (rem2 == 32'd0) begin
                bits_nxt  = '0;
                cnt_nxt   = '0;
                phase_nxt = PH_SIZE;
                lc_nxt    = '0;
                asm_nxt   = '0;
              end
            end
          end
        end
        default: begin
          // size header, also taken for the unused phase code
          phase_nxt = PH_SIZE;
          asm_nxt   = {asm_r[23:0], byte_in};
          lc_nxt    = lc_r + LC_W'(1);
          if (lc_nxt >= LC_W'(HDR_BYTES)) begin
            rem_nxt   = {1'b0, asm_nxt[31:1]} + {31'd0, asm_nxt[0]};
            lc_nxt    = '0;
            phase_nxt = PH_DICT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      lc_r    <= '0;
      asm_r   <= '0;
      rem_r   <= '0;
      bits_r  <= '0;
      cnt_r   <= '0;
      sym0_r  <= '0;
      sym1_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      lc_r    <= lc_nxt;
      asm_r   <= asm_nxt;
      rem_r   <= rem_nxt;
      bits_r  <= bits_nxt;
      cnt_r   <= cnt_nxt;
      sym0_r  <= sym0_nxt;
      sym1_r  <= sym1_nxt;
    end
  end

`ifndef SYNTHESIS
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    sym1_r.valid |-> sym0_r.valid)
    else $error("second symbol without first");

  a_nothing_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (sym0_r.valid && sym0_r.last) |-> !sym1_r.valid)
    else $error("symbol decoded after final halfword");

  a_last_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
    ((sym0_r.valid && sym0_r.last) || (sym1_r.valid && sym1_r.last))
      |-> (phase_r == PH_SIZE && cnt_r == '0 && lc_r == '0))
    else $error("stream not closed after final halfword");
`endif

endmodule
`default_nettype wire

/* src/dhd_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhd_out_fifo
// small result queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
module dhd_out_fifo
  import dhd_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push0,
  input  wire out_t           ent0,
  input  wire logic           push1,
  input  wire out_t           ent1,
  input  wire logic           pop,
  output out_t                head,
  output logic                nonempty,
  output logic [FIFO_AW:0]    count
);

  out_t               q_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt;
  logic [FIFO_AW-1:0] rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic [FIFO_AW:0]   npush;
  logic               do_pop;

  assign npush    = (FIFO_AW+1)'(push0) + (FIFO_AW+1)'(push1);
  assign nonempty = (cnt_r != '0);
  assign do_pop   = pop && nonempty;
  assign head     = q_r[rp_r];
  assign count    = cnt_r;

  always_comb begin
    wp_nxt  = wp_r + FIFO_AW'(npush);
    rp_nxt  = rp_r + FIFO_AW'(do_pop);
    cnt_nxt = cnt_r + npush - (FIFO_AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      q_r[wp_r] <= ent0;
    end
    if (push1) begin
      q_r[wp_r + FIFO_AW'(1)] <= ent1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} + {1'b0, npush}) <= ((FIFO_AW+2)'(FIFO_DEPTH) + (FIFO_AW+2)'(do_pop)))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0)
    else $error("second push without first");
`endif

endmodule
`default_nettype wire

/* src/dictionary_halfword_decompressor_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dictionary_halfword_decompressor_core
// byte stream in: size header, 64-word dictionary, then flag-coded symbols;
// decoded halfwords out, final one marked with tlast
// ----------------------------------------------------------------------------
//  channel   ports                     word
//  input     in_tvalid/in_tready       in_tdata[7:0]   = in_byte
//  result    out_tvalid/out_tready     out_tdata[15:0] = halfword, out_tlast = last
//
//  one byte per cycle while the result queue has room for two more words
//  a byte is decoded in its accept cycle; the registered dictionary read
//  pushes its halfwords into the queue in the next cycle
//  bytes yielding two halfwords can hold input back until the queue drains
//  rst_n is synchronous; the dictionary is not cleared by reset
// ----------------------------------------------------------------------------
module dictionary_halfword_decompressor_core
  import dhd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] halfword
  output logic             out_tlast
);

  logic             take;
  dict_wr_t         dict_wr;
  dict_rd_t         dict_rd;
  sym_t             sym0_r, sym1_r;
  logic [15:0]      rdata0, rdata1;
  out_t             ent0, ent1, head;
  logic             nonempty;
  logic [FIFO_AW:0] fcount;
  logic [FIFO_AW:0] pending;

  // queue words plus words still at the dictionary read must leave two free
  assign pending   = fcount + (FIFO_AW+1)'(sym0_r.valid) + (FIFO_AW+1)'(sym1_r.valid);
  assign in_tready = (pending <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign take      = in_tvalid && in_tready;

  dhd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .byte_in (in_tdata),
    .dict_wr (dict_wr),
    .dict_rd (dict_rd),
    .sym0_r  (sym0_r),
    .sym1_r  (sym1_r)
  );

  dhd_dict_ram u_dict (
    .clk    (clk),
    .wr     (dict_wr),
    .rd     (dict_rd),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  assign ent0.halfword = sym0_r.lit ? sym0_r.value : rdata0;
  assign ent0.last     = sym0_r.last;
  assign ent1.halfword = sym1_r.lit ? sym1_r.value : rdata1;
  assign ent1.last     = sym1_r.last;

  dhd_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push0    (sym0_r.valid),
    .ent0     (ent0),
    .push1    (sym1_r.valid),
    .ent1     (ent1),
    .pop      (out_tready),
    .head     (head),
    .nonempty (nonempty),
    .count    (fcount)
  );

  assign out_tvalid = nonempty;
  assign out_tdata  = head.halfword;
  assign out_tlast  = head.last;

endmodule
`default_nettype wire
